/* hw/rtl/hac_pkg.sv */
// ----------------------------------------------------------------------------
// hac_pkg
// shared types, constants and md5 tables for the hidden attribute cipher
// ----------------------------------------------------------------------------
package hac_pkg;

  localparam int SECRET_BYTES_DEF = 32;
  localparam int VECTOR_BYTES_DEF = 16;

  localparam int CFG_W   = 64;
  localparam int CFG_IDX = 3;
  localparam int IN_W    = 40;
  localparam int OUT_W   = 32;

  localparam logic [CFG_IDX-1:0] REG_SECRET_0  = 3'd0;
  localparam logic [CFG_IDX-1:0] REG_SECRET_1  = 3'd1;
  localparam logic [CFG_IDX-1:0] REG_SECRET_2  = 3'd2;
  localparam logic [CFG_IDX-1:0] REG_SECRET_3  = 3'd3;
  localparam logic [CFG_IDX-1:0] REG_SECRET_LEN = 3'd4;
  localparam logic [CFG_IDX-1:0] REG_VECTOR_LO = 3'd5;
  localparam logic [CFG_IDX-1:0] REG_VECTOR_HI = 3'd6;
  localparam logic [CFG_IDX-1:0] REG_VECTOR_LEN = 3'd7;

  localparam logic MODE_START = 1'b0;
  localparam logic DIR_REVEAL = 1'b0;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NO_VECTOR = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG  = 2'd2;

  localparam logic [31:0] MD_IV_A = 32'h67452301;
  localparam logic [31:0] MD_IV_B = 32'hefcdab89;
  localparam logic [31:0] MD_IV_C = 32'h98badcfe;
  localparam logic [31:0] MD_IV_D = 32'h10325476;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_PROCESS
  } state_t;

  typedef struct packed {
    logic load_start;
    logic load_rekey;
    logic capture;
    logic do_byte;
  } cmd_t;

  typedef struct packed {
    logic rem_zero;
    logic rekey;
    logic md_done;
    logic out_free;
  } stat_t;

  function automatic logic [4:0] md_shift(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] md_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

endpackage

/* hw/rtl/hac_md5.sv */
// ----------------------------------------------------------------------------
// hac_md5
// iterative md5 compression, one round per cycle over one 512-bit block
// ----------------------------------------------------------------------------
module hac_md5 (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  logic [511:0] block,
  output logic         done,
  output logic [127:0] digest
);
  import hac_pkg::*;

  logic [511:0] blk;
  logic [31:0]  a, b, c, d;
  logic [5:0]   rnd;
  logic         busy;
  logic [31:0]  f, w, sum, b_next;
  logic [3:0]   g;
  logic [63:0]  rot;
  logic [5:0]   i5, i3, i7;

  always_comb begin
    i5 = 6'(rnd * 6'd5 + 6'd1);
    i3 = 6'(rnd * 6'd3 + 6'd5);
    i7 = 6'(rnd * 6'd7);
    case (rnd[5:4])
      2'd0: begin
        f = (b & c) | (~b & d);
        g = rnd[3:0];
      end
      2'd1: begin
        f = (d & b) | (~d & c);
        g = i5[3:0];
      end
      2'd2: begin
        f = b ^ c ^ d;
        g = i3[3:0];
      end
      default: begin
        f = c ^ (b | ~d);
        g = i7[3:0];
      end
    endcase
    w      = blk[32*g +: 32];
    sum    = a + f + md_k(rnd) + w;
    rot    = {sum, sum} << md_shift(rnd);
    b_next = b + rot[63:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        rnd <= rnd + 6'd1;
        if (rnd == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      blk <= block;
      a   <= MD_IV_A;
      b   <= MD_IV_B;
      c   <= MD_IV_C;
      d   <= MD_IV_D;
    end else if (busy) begin
      a <= d;
      d <= c;
      c <= b;
      b <= b_next;
    end
  end

  assign digest = {d + MD_IV_D, c + MD_IV_C, b + MD_IV_B, a + MD_IV_A};

endmodule

/* hw/rtl/hac_datapath.sv */
// ----------------------------------------------------------------------------
// hac_datapath
// config registers, message builder, keystream state and output register
// ----------------------------------------------------------------------------
module hac_datapath #(
  parameter int SECRET_BYTES = hac_pkg::SECRET_BYTES_DEF,
  parameter int VECTOR_BYTES = hac_pkg::VECTOR_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [hac_pkg::CFG_IDX-1:0]  cfg_index,
  input  logic [hac_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         direction,
  input  logic [15:0]                  attr_type,
  input  logic [9:0]                   body_length,
  input  logic [7:0]                   data_byte,
  input  hac_pkg::cmd_t                cmd,
  output hac_pkg::stat_t               st,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [hac_pkg::OUT_W-1:0]    m_tdata,
  output logic                         m_tlast
);
  import hac_pkg::*;

  localparam int SEC_MAX = (SECRET_BYTES < 32) ? SECRET_BYTES : 32;
  localparam int VEC_MAX = (VECTOR_BYTES < 16) ? VECTOR_BYTES : 16;

  logic [63:0]  secret_word [4];
  logic [5:0]   secret_length;
  logic [63:0]  vector_low, vector_high;
  logic [4:0]   vector_length;

  logic [127:0] keystream;
  logic [127:0] segment;
  logic [4:0]   seg_pos;
  logic [9:0]   remaining;
  logic [15:0]  hidden_len;
  logic         cur_dir;
  logic [9:0]   byte_idx;
  logic [7:0]   held_byte;

  logic [7:0]   out_byte;
  logic [1:0]   status;
  logic [15:0]  orig_len;

  logic [5:0]   ns;
  logic [4:0]   nv;
  logic [7:0]   sbyte [32];
  logic [127:0] vtail, tail;
  logic [4:0]   nt;
  logic [6:0]   head, msg_len, q, r;
  logic [8:0]   bit_len;
  logic [511:0] block;
  logic         md_done;
  logic [127:0] digest;

  logic [7:0]   ob, plain;
  logic [15:0]  hidden_next;
  logic [9:0]   idx_next;
  logic [1:0]   status_next;

  always_comb begin
    ns = (secret_length > 6'(SEC_MAX)) ? 6'(SEC_MAX) : secret_length;
    nv = (vector_length > 5'(VEC_MAX)) ? 5'(VEC_MAX) : vector_length;
    for (int i = 0; i < 32; i++) begin
      sbyte[i] = secret_word[i / 8][8 * (7 - (i % 8)) +: 8];
    end
    for (int i = 0; i < 8; i++) begin
      vtail[8 * i +: 8]       = vector_low[8 * (7 - i) +: 8];
      vtail[8 * (i + 8) +: 8] = vector_high[8 * (7 - i) +: 8];
    end
    head    = cmd.load_start ? 7'd2 : 7'd0;
    tail    = cmd.load_start ? vtail : segment;
    nt      = cmd.load_start ? nv : 5'd16;
    msg_len = head + 7'(ns) + 7'(nt);
    bit_len = {msg_len[5:0], 3'b000};
    block   = '0;
    for (int p = 0; p < 56; p++) begin
      q = 7'(p) - head;
      r = q - 7'(ns);
      if (7'(p) < head) begin
        block[8 * p +: 8] = (p == 0) ? attr_type[15:8] : attr_type[7:0];
      end else if (q < 7'(ns)) begin
        block[8 * p +: 8] = sbyte[q[4:0]];
      end else if (r < 7'(nt)) begin
        block[8 * p +: 8] = tail[8 * r[3:0] +: 8];
      end else if (7'(p) == msg_len) begin
        block[8 * p +: 8] = 8'h80;
      end
    end
    block[8 * 56 +: 8] = bit_len[7:0];
    block[8 * 57 +: 8] = {7'd0, bit_len[8]};
  end

  hac_md5 u_md5 (
    .clk    (clk),
    .rst    (rst),
    .go     (cmd.load_start | cmd.load_rekey),
    .block  (block),
    .done   (md_done),
    .digest (digest)
  );

  always_comb begin
    ob       = held_byte ^ keystream[8 * seg_pos[3:0] +: 8];
    plain    = cur_dir ? held_byte : ob;
    idx_next = byte_idx + 10'd1;
    if (byte_idx == 10'd0) begin
      hidden_next = {plain, hidden_len[7:0]};
    end else if (byte_idx == 10'd1) begin
      hidden_next = {hidden_len[15:8], plain};
    end else begin
      hidden_next = hidden_len;
    end
    if (nv == 5'd0) begin
      status_next = STATUS_NO_VECTOR;
    end else if (cur_dir == DIR_REVEAL &&
                 ({1'b0, hidden_next} + 17'd2) > {7'd0, idx_next}) begin
      status_next = STATUS_TOO_LONG;
    end else begin
      status_next = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        secret_word[i] <= '0;
      end
      secret_length <= '0;
      vector_low    <= '0;
      vector_high   <= '0;
      vector_length <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SECRET_0:   secret_word[0] <= cfg_data;
        REG_SECRET_1:   secret_word[1] <= cfg_data;
        REG_SECRET_2:   secret_word[2] <= cfg_data;
        REG_SECRET_3:   secret_word[3] <= cfg_data;
        REG_SECRET_LEN: secret_length  <= cfg_data[5:0];
        REG_VECTOR_LO:  vector_low     <= cfg_data;
        REG_VECTOR_HI:  vector_high    <= cfg_data;
        REG_VECTOR_LEN: vector_length  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      keystream  <= '0;
      segment    <= '0;
      seg_pos    <= '0;
      remaining  <= '0;
      hidden_len <= '0;
      cur_dir    <= 1'b0;
      byte_idx   <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tready && !cmd.do_byte) begin
        m_tvalid <= 1'b0;
      end
      if (md_done) begin
        keystream <= digest;
      end
      if (cmd.load_start) begin
        cur_dir    <= direction;
        remaining  <= body_length;
        byte_idx   <= '0;
        seg_pos    <= '0;
        hidden_len <= '0;
      end
      if (cmd.load_rekey) begin
        seg_pos <= '0;
      end
      if (cmd.do_byte) begin
        segment[8 * seg_pos[3:0] +: 8] <= cur_dir ? ob : held_byte;
        hidden_len <= hidden_next;
        seg_pos    <= seg_pos + 5'd1;
        byte_idx   <= idx_next;
        remaining  <= remaining - 10'd1;
        m_tvalid   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      held_byte <= data_byte;
    end
    if (cmd.do_byte) begin
      out_byte <= ob;
      m_tlast  <= (remaining == 10'd1);
      status   <= (remaining == 10'd1) ? status_next : STATUS_OK;
      orig_len <= (remaining == 10'd1 && cur_dir == DIR_REVEAL) ? hidden_next : 16'd0;
    end
  end

  assign m_tdata     = {6'd0, orig_len, status, out_byte};
  assign st.rem_zero = (remaining == 10'd0);
  assign st.rekey    = seg_pos[4];
  assign st.md_done  = md_done;
  assign st.out_free = !m_tvalid || m_tready;

endmodule

/* hw/rtl/hac_ctrl.sv */
// ----------------------------------------------------------------------------
// hac_ctrl
// sequencer: accepts beats, starts hashes and schedules byte processing
// ----------------------------------------------------------------------------
module hac_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  input  logic            mode,
  input  hac_pkg::stat_t  st,
  output logic            s_tready,
  output hac_pkg::cmd_t   cmd
);
  import hac_pkg::*;

  state_t state, state_next;
  logic   pend, pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

  always_comb begin
    state_next = state;
    pend_next  = pend;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (mode == MODE_START) begin
            cmd.load_start = 1'b1;
            pend_next      = 1'b0;
            state_next     = ST_HASH;
          end else if (!st.rem_zero) begin
            cmd.capture = 1'b1;
            if (st.rekey) begin
              cmd.load_rekey = 1'b1;
              pend_next      = 1'b1;
              state_next     = ST_HASH;
            end else begin
              state_next = ST_PROCESS;
            end
          end
        end
      end
      ST_HASH: begin
        if (st.md_done) begin
          state_next = pend ? ST_PROCESS : ST_IDLE;
        end
      end
      ST_PROCESS: begin
        if (st.out_free) begin
          cmd.do_byte = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* hw/rtl/hidden_attribute_cipher.sv */
// ----------------------------------------------------------------------------
// hidden_attribute_cipher
// hides or reveals one tunnel attribute body with an md5 keystream
// ----------------------------------------------------------------------------
// Input stream: tuser is the mode (0 start, 1 body byte). A start beat loads
// direction, attribute type and body length and hashes the first keystream
// block; each body beat within the body length is xored with the keystream
// for one output beat, tlast on the last byte with status and revealed length.
// Config: cfg_write with cfg_index/cfg_data, only while the block is idle.
// Timing: one beat at a time. A start beat waits for one md5 compression
// at one round per cycle. A body byte is captured and then processed;
// when it opens a new 16-byte segment the next block is hashed first.
// The output beat sits in a register; a stalled receiver holds it while
// the next input beat is already taken, and a later byte waits for the
// register to free up. Reset clears control state, config and keystream
// registers to zero; no pass is needed before the first beat.
// ----------------------------------------------------------------------------
module hidden_attribute_cipher #(
  parameter int SECRET_BYTES = hac_pkg::SECRET_BYTES_DEF,
  parameter int VECTOR_BYTES = hac_pkg::VECTOR_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [hac_pkg::CFG_IDX-1:0] cfg_index,
  input  logic [hac_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // direction, attr_type, body_length, data_byte
  input  logic [hac_pkg::IN_W-1:0]    s_tdata,
  // mode
  input  logic                        s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // out_byte, status, original_length
  output logic [hac_pkg::OUT_W-1:0]   m_tdata,
  output logic                        m_tlast
);
  import hac_pkg::*;

  cmd_t  cmd;
  stat_t st;

  hac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .mode     (s_tuser),
    .st       (st),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  hac_datapath #(
    .SECRET_BYTES (SECRET_BYTES),
    .VECTOR_BYTES (VECTOR_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .direction   (s_tdata[0]),
    .attr_type   (s_tdata[16:1]),
    .body_length (s_tdata[26:17]),
    .data_byte   (s_tdata[34:27]),
    .cmd         (cmd),
    .st          (st),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

endmodule

/* hw/rtl/hac_checker.sv */
// ----------------------------------------------------------------------------
// hac_checker
// port-level checks on the output stream of the cipher
// ----------------------------------------------------------------------------
module hac_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [hac_pkg::OUT_W-1:0] m_tdata,
  input logic                      m_tlast
);
  import hac_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  a_status_on_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[9:8] == STATUS_OK)
    else $error("status set on a byte that is not last");

  a_len_on_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[25:10] == 16'd0)
    else $error("length set on a byte that is not last");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output beat after reset");

endmodule

bind hidden_attribute_cipher hac_checker u_hac_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// hidden_attribute_cipher testbench: start and body beats go in with random
// gaps and the output side stalls at random. Every output beat is compared
// with a queue of bytes worked out by a local md5 keystream predictor.
// ----------------------------------------------------------------------------
module tb;
  import hac_pkg::*;

  localparam logic MODE_BODY = 1'b1;
  localparam logic DIR_HIDE  = 1'b1;

  typedef logic [15:0][7:0] blk16_t;

  typedef struct packed {
    logic [7:0]  cipher_byte;
    logic        final_byte;
    logic [1:0]  status;
    logic [15:0] orig_len;
  } out_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic m_tlast;

  hidden_attribute_cipher dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // md5 round constants and shifts
  logic [31:0] rnd_k [64] = '{
    32'hd76aa478,32'he8c7b756,32'h242070db,32'hc1bdceee,32'hf57c0faf,32'h4787c62a,
    32'ha8304613,32'hfd469501,32'h698098d8,32'h8b44f7af,32'hffff5bb1,32'h895cd7be,
    32'h6b901122,32'hfd987193,32'ha679438e,32'h49b40821,32'hf61e2562,32'hc040b340,
    32'h265e5a51,32'he9b6c7aa,32'hd62f105d,32'h02441453,32'hd8a1e681,32'he7d3fbc8,
    32'h21e1cde6,32'hc33707d6,32'hf4d50d87,32'h455a14ed,32'ha9e3e905,32'hfcefa3f8,
    32'h676f02d9,32'h8d2a4c8a,32'hfffa3942,32'h8771f681,32'h6d9d6122,32'hfde5380c,
    32'ha4beea44,32'h4bdecfa9,32'hf6bb4b60,32'hbebfbc70,32'h289b7ec6,32'heaa127fa,
    32'hd4ef3085,32'h04881d05,32'hd9d4d039,32'he6db99e5,32'h1fa27cf8,32'hc4ac5665,
    32'hf4292244,32'h432aff97,32'hab9423a7,32'hfc93a039,32'h655b59c3,32'h8f0ccc92,
    32'hffeff47d,32'h85845dd1,32'h6fa87e4f,32'hfe2ce6e0,32'ha3014314,32'h4e0811a1,
    32'hf7537e82,32'hbd3af235,32'h2ad7d2bb,32'heb86d391};
  int rnd_s [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  // predictor copy of registers and state
  logic [63:0] key_word [4];
  logic [5:0]  key_len;
  logic [63:0] iv_lo, iv_hi;
  logic [4:0]  iv_len;
  blk16_t      ks_block, ct_segment;
  int          seg_pos, bytes_left, byte_idx;
  logic [15:0] hidden_len;
  logic        cur_dir;
  logic [7:0]  hash_msg [64];

  out_beat_t expected_beats[$];
  int errors = 0;
  int item_count = 0;
  bit quiet = 0;

  function automatic blk16_t md5_of(input int len);
    logic [7:0] pad [128];
    logic [31:0] h [4];
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t, sum;
    logic [63:0] bits;
    int total, g;
    blk16_t res;
    for (int i = 0; i < 128; i++) pad[i] = (i < len) ? hash_msg[i] : 8'h00;
    pad[len] = 8'h80;
    total = (len + 9 <= 64) ? 64 : 128;
    bits = 64'(len) * 8;
    for (int i = 0; i < 8; i++) pad[total - 8 + i] = bits[8*i +: 8];
    h = '{MD_IV_A, MD_IV_B, MD_IV_C, MD_IV_D};
    for (int base = 0; base < total; base += 64) begin
      for (int i = 0; i < 16; i++)
        w[i] = {pad[base+4*i+3], pad[base+4*i+2], pad[base+4*i+1], pad[base+4*i]};
      a = h[0]; b = h[1]; c = h[2]; d = h[3];
      for (int i = 0; i < 64; i++) begin
        if (i < 16) begin
          f = (b & c) | (~b & d); g = i;
        end else if (i < 32) begin
          f = (d & b) | (~d & c); g = (5*i + 1) % 16;
        end else if (i < 48) begin
          f = b ^ c ^ d; g = (3*i + 5) % 16;
        end else begin
          f = c ^ (b | ~d); g = (7*i) % 16;
        end
        t = d; d = c; c = b;
        sum = a + f + rnd_k[i] + w[g];
        b = b + ((sum << rnd_s[(i/16)*4 + i%4]) | (sum >> (32 - rnd_s[(i/16)*4 + i%4])));
        a = t;
      end
      h[0] += a; h[1] += b; h[2] += c; h[3] += d;
    end
    for (int i = 0; i < 16; i++) res[i] = h[i/4][8*(i%4) +: 8];
    return res;
  endfunction

  function automatic int secret_in_use();
    return (key_len > 32) ? 32 : int'(key_len);
  endfunction

  function automatic int vector_in_use();
    return (iv_len > 16) ? 16 : int'(iv_len);
  endfunction

  function automatic logic [7:0] secret_byte(input int i);
    return key_word[i/8][8*(7 - i%8) +: 8];
  endfunction

  task automatic predict_beat(input logic mode, input logic dir, input logic [15:0] attr,
                              input logic [9:0] len, input logic [7:0] din);
    int n;
    logic [7:0] ob, plain;
    out_beat_t e;
    if (mode == MODE_START) begin
      cur_dir = dir; bytes_left = len; byte_idx = 0; seg_pos = 0; hidden_len = 0;
      hash_msg[0] = attr[15:8]; hash_msg[1] = attr[7:0];
      n = 2;
      for (int i = 0; i < secret_in_use(); i++) hash_msg[n++] = secret_byte(i);
      for (int i = 0; i < vector_in_use(); i++)
        hash_msg[n++] = (i < 8) ? iv_lo[8*(7-i) +: 8] : iv_hi[8*(15-i) +: 8];
      ks_block = md5_of(n);
    end else if (bytes_left != 0) begin
      if (seg_pos >= 16) begin
        n = 0;
        for (int i = 0; i < secret_in_use(); i++) hash_msg[n++] = secret_byte(i);
        for (int i = 0; i < 16; i++) hash_msg[n++] = ct_segment[i];
        ks_block = md5_of(n);
        seg_pos = 0;
      end
      ob = din ^ ks_block[seg_pos];
      ct_segment[seg_pos] = cur_dir ? ob : din;
      plain = cur_dir ? din : ob;
      if (byte_idx == 0) hidden_len[15:8] = plain;
      else if (byte_idx == 1) hidden_len[7:0] = plain;
      seg_pos++;
      byte_idx = (byte_idx + 1) % 1024;
      bytes_left--;
      e = '{cipher_byte: ob, final_byte: 1'b0, status: STATUS_OK, orig_len: 16'h0};
      if (bytes_left == 0) begin
        e.final_byte = 1'b1;
        if (vector_in_use() == 0) e.status = STATUS_NO_VECTOR;
        else if (cur_dir == DIR_REVEAL && int'(hidden_len) + 2 > byte_idx)
          e.status = STATUS_TOO_LONG;
        if (cur_dir == DIR_REVEAL) e.orig_len = hidden_len;
      end
      expected_beats.push_back(e);
    end
  endtask

  // one input beat; called and returns at a rising edge
  task automatic send_beat(input logic mode, input logic dir, input logic [15:0] attr,
                           input logic [9:0] len, input logic [7:0] din);
    int gap;
    gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {5'b0, din, len, attr, dir};
    do @(posedge clk); while (!s_tready);
    predict_beat(mode, dir, attr, len, din);
    item_count++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX-1:0] idx, input logic [63:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_SECRET_0, REG_SECRET_1, REG_SECRET_2, REG_SECRET_3: key_word[idx[1:0]] = val;
      REG_SECRET_LEN: key_len = val[5:0];
      REG_VECTOR_LO:  iv_lo = val;
      REG_VECTOR_HI:  iv_hi = val;
      REG_VECTOR_LEN: iv_len = val[4:0];
      default: ;
    endcase
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic load_settings(input logic [63:0] fill, input logic [5:0] slen,
                               input logic [4:0] vlen);
    wait_idle();
    write_reg(REG_SECRET_0, fill);
    write_reg(REG_SECRET_1, ~fill);
    write_reg(REG_SECRET_2, fill ^ 64'h0123456789abcdef);
    write_reg(REG_SECRET_3, rand64());
    write_reg(REG_SECRET_LEN, slen);
    write_reg(REG_VECTOR_LO, rand64());
    write_reg(REG_VECTOR_HI, fill);
    write_reg(REG_VECTOR_LEN, vlen);
  endtask

  // whole attribute; on reveal with craft set the length field is steered
  task automatic run_attr(input logic dir, input logic [15:0] attr, input int len,
                          input bit craft, input logic [15:0] want_len);
    logic [7:0] d;
    send_beat(MODE_START, dir, attr, 10'(len), 8'($urandom));
    for (int i = 0; i < len; i++) begin
      d = 8'($urandom);
      if (craft && dir == DIR_REVEAL && i < 2)
        d = (i == 0 ? want_len[15:8] : want_len[7:0]) ^ ks_block[i];
      send_beat(MODE_BODY, dir, 16'($urandom), 10'($urandom), d);
    end
  endtask

  task automatic test_reset_state();
    run_attr(DIR_HIDE, 16'h0000, 5, 0, 0);
    run_attr(DIR_REVEAL, 16'hffff, 3, 0, 0);
  endtask

  task automatic test_register_extremes();
    load_settings(64'hffff_ffff_ffff_ffff, 6'd32, 5'd16);
    run_attr(DIR_HIDE, 16'hffff, 18, 0, 0);
    load_settings(64'h0, 6'd0, 5'd1);
    run_attr(DIR_REVEAL, 16'h0001, 4, 1, 16'd2);
    load_settings(rand64(), 6'd63, 5'd31);
    run_attr(DIR_REVEAL, 16'h8000, 17, 1, 16'd15);
    load_settings(rand64(), 6'd1, 5'd0);
    run_attr(DIR_REVEAL, 16'h1234, 2, 1, 16'd0);
  endtask

  task automatic test_special_cases();
    load_settings(rand64(), 6'd16, 5'd16);
    // stray body beats with nothing open
    send_beat(MODE_BODY, DIR_HIDE, 16'h0, 10'h0, 8'hff);
    send_beat(MODE_BODY, DIR_REVEAL, 16'hffff, 10'h3ff, 8'h00);
    run_attr(DIR_HIDE, 16'h0007, 0, 0, 0);
    send_beat(MODE_BODY, DIR_HIDE, 16'h0, 10'h0, 8'h5a);
    // abandoned attribute
    send_beat(MODE_START, DIR_HIDE, 16'h0024, 10'd10, 8'h00);
    send_beat(MODE_BODY, DIR_HIDE, 16'h0, 10'h0, 8'h11);
    run_attr(DIR_REVEAL, 16'h0024, 1, 1, 16'd0);
    run_attr(DIR_REVEAL, 16'h0024, 8, 1, 16'd6);
    run_attr(DIR_REVEAL, 16'h0024, 8, 1, 16'd7);
    run_attr(DIR_REVEAL, 16'h0024, 8, 1, 16'hffff);
    // secret changed part way through an attribute
    send_beat(MODE_START, DIR_HIDE, 16'hbeef, 10'd20, 8'h00);
    for (int i = 0; i < 10; i++) send_beat(MODE_BODY, DIR_HIDE, 16'h0, 10'h0, 8'($urandom));
    wait_idle();
    write_reg(REG_SECRET_0, rand64());
    write_reg(REG_SECRET_LEN, 6'd8);
    for (int i = 0; i < 10; i++) send_beat(MODE_BODY, DIR_HIDE, 16'h0, 10'h0, 8'($urandom));
  endtask

  task automatic test_random_traffic(input int item_goal);
    int len, pick;
    logic dir;
    while (item_count < item_goal) begin
      if ($urandom_range(0, 9) == 0) begin
        pick = $urandom_range(0, 3);
        load_settings(rand64(), pick == 0 ? 6'd32 : 6'($urandom_range(0, 63)),
                      pick == 1 ? 5'd0 : 5'($urandom_range(1, 31)));
      end
      dir = 1'($urandom);
      pick = $urandom_range(0, 39);
      len = (pick == 0) ? $urandom_range(200, 1023) : $urandom_range(0, 40);
      if (pick == 1) begin
        send_beat(MODE_BODY, dir, 16'($urandom), 10'($urandom), 8'($urandom));
      end else if (pick == 2) begin
        send_beat(MODE_START, dir, 16'($urandom), 10'(len + 2), 8'($urandom));
        repeat (len / 2) send_beat(MODE_BODY, dir, 16'h0, 10'h0, 8'($urandom));
      end else begin
        run_attr(dir, 16'($urandom), len, $urandom_range(0, 3) != 0,
                 (len >= 2) ? 16'($urandom_range(0, len - 1)) : 16'($urandom));
      end
    end
  endtask

  task automatic test_steady_stream();
    wait_idle();
    quiet = 1;
    for (int i = 0; i < 6; i++)
      run_attr(1'($urandom), 16'($urandom), $urandom_range(1, 40), 1, 16'd3);
  endtask

  // output side stalls
  int stall_left = 0;
  always @(posedge clk) begin
    if (quiet) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 14);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // output checker
  always @(posedge clk) begin
    out_beat_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_beats.size() == 0) begin
        $display("%0t unexpected beat: actual %h last %b", $time, m_tdata, m_tlast);
        errors++;
      end else begin
        e = expected_beats.pop_front();
        if (m_tdata[7:0] !== e.cipher_byte || m_tlast !== e.final_byte ||
            m_tdata[9:8] !== e.status || m_tdata[25:10] !== e.orig_len) begin
          $display("%0t byte/last/status/len: expected %h %b %0d %h actual %h %b %0d %h",
                   $time, e.cipher_byte, e.final_byte, e.status, e.orig_len,
                   m_tdata[7:0], m_tlast, m_tdata[9:8], m_tdata[25:10]);
          errors++;
        end
      end
    end
  end

  initial begin
    key_word = '{default: '0};
    key_len = '0; iv_lo = '0; iv_hi = '0; iv_len = '0;
    ks_block = '0; ct_segment = '0;
    seg_pos = 0; bytes_left = 0; byte_idx = 0; hidden_len = '0; cur_dir = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_register_extremes();
    test_special_cases();
    test_random_traffic(1450);
    test_steady_stream();
    wait_idle();
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("hidden_attribute_cipher: match");
    end else begin
      $display("hidden_attribute_cipher: mismatch");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("hidden_attribute_cipher: mismatch");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/hac_pkg.sv
hw/rtl/hac_md5.sv
hw/rtl/hac_datapath.sv
hw/rtl/hac_ctrl.sv
hw/rtl/hidden_attribute_cipher.sv
hw/rtl/hac_checker.sv
verif/tb.sv
